FILE: rtl/wsm_pkg.sv
package wsm_pkg;

  localparam int ID_W     = 31;
  localparam int MAC_W    = 48;
  localparam int PROTO_W  = 8;
  localparam int VLAN_W   = 13;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  // Most results a single lookup may produce, and the width of a count up to it.
  localparam int MAX_RESULTS = 32;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EXISTS    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

  localparam logic [MAC_W-1:0]  BCAST_MAC = {MAC_W{1'b1}};
  localparam logic [VLAN_W-1:0] VLAN_ANY  = {VLAN_W{1'b1}};

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [MAC_W-1:0]   local_mac;
    logic [MAC_W-1:0]   remote_mac;
    logic [PROTO_W-1:0] proto;
    logic [VLAN_W-1:0]  vlan;
  } entry_t;

  typedef struct packed {
    logic id_lt;
    logic id_eq;
    logic hit;
  } cmp_t;

endpackage

FILE: rtl/wsm_in_if.sv
interface wsm_in_if;
  logic                                valid;
  logic                                ready;
  logic [wsm_pkg::KIND_W-1:0]          kind;
  logic [wsm_pkg::ID_W-1:0]            sock_id;
  logic [wsm_pkg::MAC_W-1:0]           local_mac;
  logic [wsm_pkg::MAC_W-1:0]           remote_mac;
  logic [wsm_pkg::PROTO_W-1:0]         proto_num;
  logic signed [wsm_pkg::VLAN_W-1:0]   vlan_num;

  modport source (output valid, kind, sock_id, local_mac, remote_mac, proto_num, vlan_num,
                  input ready);
  modport sink (input valid, kind, sock_id, local_mac, remote_mac, proto_num, vlan_num,
                output ready);
endinterface

FILE: rtl/wsm_out_if.sv
interface wsm_out_if;
  logic                           valid;
  logic                           ready;
  logic [wsm_pkg::STATUS_W-1:0]   status;
  logic                           matched;
  logic [wsm_pkg::ID_W-1:0]       match_id;
  logic                           last;

  modport source (output valid, status, matched, match_id, last, input ready);
  modport sink (input valid, status, matched, match_id, last, output ready);
endinterface

FILE: rtl/wsm_mem.sv
module wsm_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  wsm_pkg::entry_t       wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output wsm_pkg::entry_t       rdata
);

  wsm_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds when no read is issued, so a stalled scan keeps its entry.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/wsm_cmp.sv
module wsm_cmp (
  input  wsm_pkg::entry_t ent,
  input  wsm_pkg::entry_t key,
  output wsm_pkg::cmp_t   res
);

  logic lmac_ok;
  logic rmac_ok;
  logic proto_ok;
  logic vlan_ok;

  // A zero MAC in the entry or a broadcast MAC in the frame matches anything.
  assign lmac_ok  = (ent.local_mac == '0) || (key.local_mac == wsm_pkg::BCAST_MAC) ||
                    (key.local_mac == ent.local_mac);
  assign rmac_ok  = (ent.remote_mac == '0) || (key.remote_mac == wsm_pkg::BCAST_MAC) ||
                    (key.remote_mac == ent.remote_mac);
  assign proto_ok = (ent.proto == '0) || (ent.proto == key.proto);
  assign vlan_ok  = (ent.vlan == wsm_pkg::VLAN_ANY) || (ent.vlan == key.vlan);

  assign res.id_lt = ent.id < key.id;
  assign res.id_eq = ent.id == key.id;
  assign res.hit   = lmac_ok && rmac_ok && proto_ok && vlan_ok;

endmodule

FILE: rtl/wildcard_socket_match_table_unit.sv
// Create and delete: the block takes the word, runs an id search and an entry move, and
// then posts the status word. Lookup: the block takes the word, walks the table and
// sends the final word; output stalls can hold the walk and the words back.
// One item is in work at a time; a new command word is taken only in the idle state.
// Synchronous reset empties the table and clears the sequencer and output register; the
// entry memory itself is not cleared, since only entries below the count are read.
module wildcard_socket_match_table_unit #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  wsm_in_if.sink          cmd,
  wsm_out_if.source       rsp
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    SHIFT_UP,
    SHIFT_DN,
    LOOK,
    FLUSH,
    RESP
  } state_t;

  state_t                          state;
  logic [CW-1:0]                   count;
  logic [wsm_pkg::KIND_W-1:0]      op;
  wsm_pkg::entry_t                 item;

  // Walk pointer, position found by the id search, and the index of the entry
  // sitting in the memory's read register.
  logic [CW-1:0]                   ptr;
  logic [CW-1:0]                   pos;
  logic [CW-1:0]                   didx;
  logic                            dv;

  // A lookup holds back its newest match so that the final one can be marked last.
  logic                            pend;
  logic [wsm_pkg::ID_W-1:0]        pend_id;
  logic [wsm_pkg::RES_W-1:0]       nres;

  logic [wsm_pkg::STATUS_W-1:0]    rstat;

  logic                            ovalid;
  logic [wsm_pkg::STATUS_W-1:0]    ostatus;
  logic                            omatched;
  logic [wsm_pkg::ID_W-1:0]        oid;
  logic                            olast;

  logic                            rd_en;
  logic [AW-1:0]                   raddr;
  logic                            we;
  logic [AW-1:0]                   waddr;
  wsm_pkg::entry_t                 wdata;
  wsm_pkg::entry_t                 rdata;
  wsm_pkg::cmp_t                   cmp;

  logic                            issue;
  logic                            out_free;
  logic                            limit;
  logic                            stall;
  logic                            found;
  logic                            load;
  logic [CW-1:0]                   ptr_m1;

  wsm_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // The single compare unit sees whichever entry the walk has just read.
  wsm_cmp u_cmp (
    .ent (rdata),
    .key (item),
    .res (cmp)
  );

  assign issue    = ptr < count;
  assign out_free = !ovalid || rsp.ready;
  assign ptr_m1   = ptr - 1'b1;
  // The id search stops at the first entry whose id is not below the key.
  assign found    = dv && !cmp.id_lt;
  // A held match that is already the last allowed result ends the lookup.
  assign limit    = pend && (nres == wsm_pkg::RES_W'(wsm_pkg::MAX_RESULTS - 1));
  // A new match must push the held one out, which needs room in the output register.
  assign stall    = dv && cmp.hit && pend && !out_free;
  // A new word enters the output register this cycle.
  assign load     = out_free && ((state == LOOK && !limit && dv && cmp.hit && pend) ||
                                 state == FLUSH || state == RESP);

  assign cmd.ready    = (state == IDLE);
  assign rsp.valid    = ovalid;
  assign rsp.status   = ostatus;
  assign rsp.matched  = omatched;
  assign rsp.match_id = oid;
  assign rsp.last     = olast;

  // Memory port control for each phase of the walk.
  always_comb begin
    rd_en = 1'b0;
    raddr = ptr[AW-1:0];
    we    = 1'b0;
    waddr = didx[AW-1:0];
    wdata = rdata;
    case (state)
      SCAN: begin
        if (!found && issue) begin
          rd_en = 1'b1;
        end
      end
      SHIFT_UP: begin
        // Entries move up one place from the top down; the new entry goes in last.
        if (dv) begin
          we = 1'b1;
        end
        if (ptr > pos) begin
          rd_en = 1'b1;
          raddr = ptr_m1[AW-1:0];
        end else if (!dv) begin
          we    = 1'b1;
          waddr = pos[AW-1:0];
          wdata = item;
        end
      end
      SHIFT_DN: begin
        if (dv) begin
          we = 1'b1;
        end
        if (issue) begin
          rd_en = 1'b1;
        end
      end
      LOOK: begin
        if (!limit && !stall && issue) begin
          rd_en = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      count  <= '0;
      dv     <= 1'b0;
      pend   <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (rsp.ready && !load) begin
        ovalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (cmd.valid) begin
            op              <= cmd.kind;
            item.id         <= cmd.sock_id;
            item.local_mac  <= cmd.local_mac;
            item.remote_mac <= cmd.remote_mac;
            item.proto      <= cmd.proto_num;
            item.vlan       <= $unsigned(cmd.vlan_num);
            ptr             <= '0;
            dv              <= 1'b0;
            pend            <= 1'b0;
            nres            <= '0;
            if (cmd.kind == wsm_pkg::KIND_CREATE || cmd.kind == wsm_pkg::KIND_DELETE) begin
              state <= SCAN;
            end else if (cmd.kind == wsm_pkg::KIND_LOOKUP) begin
              state <= LOOK;
            end
          end
        end
        SCAN: begin
          if (found || (!dv && !issue)) begin
            dv <= 1'b0;
            if (op == wsm_pkg::KIND_CREATE) begin
              if (found && cmp.id_eq) begin
                rstat <= wsm_pkg::STAT_EXISTS;
                state <= RESP;
              end else if (count == CW'(TABLE_DEPTH)) begin
                rstat <= wsm_pkg::STAT_FULL;
                state <= RESP;
              end else begin
                pos   <= found ? didx : count;
                ptr   <= count;
                state <= SHIFT_UP;
              end
            end else begin
              if (found && cmp.id_eq) begin
                pos   <= didx;
                ptr   <= didx + 1'b1;
                state <= SHIFT_DN;
              end else begin
                rstat <= wsm_pkg::STAT_NOT_FOUND;
                state <= RESP;
              end
            end
          end else begin
            dv   <= issue;
            didx <= ptr;
            if (issue) begin
              ptr <= ptr + 1'b1;
            end
          end
        end
        SHIFT_UP: begin
          if (ptr > pos) begin
            dv   <= 1'b1;
            didx <= ptr;
            ptr  <= ptr_m1;
          end else begin
            dv <= 1'b0;
            if (!dv) begin
              count <= count + 1'b1;
              rstat <= wsm_pkg::STAT_OK;
              state <= RESP;
            end
          end
        end
        SHIFT_DN: begin
          if (issue) begin
            dv   <= 1'b1;
            didx <= ptr_m1;
            ptr  <= ptr + 1'b1;
          end else begin
            dv <= 1'b0;
            if (!dv) begin
              count <= count - 1'b1;
              rstat <= wsm_pkg::STAT_OK;
              state <= RESP;
            end
          end
        end
        LOOK: begin
          if (limit || (!dv && !issue)) begin
            state <= FLUSH;
          end else if (!stall) begin
            dv <= issue;
            if (issue) begin
              ptr <= ptr + 1'b1;
            end
            if (dv && cmp.hit) begin
              if (pend) begin
                ovalid   <= 1'b1;
                ostatus  <= wsm_pkg::STAT_OK;
                omatched <= 1'b1;
                oid      <= pend_id;
                olast    <= 1'b0;
                nres     <= nres + 1'b1;
              end
              pend    <= 1'b1;
              pend_id <= rdata.id;
            end
          end
        end
        FLUSH: begin
          // Either the held match closes the list, or a single no-match word is sent.
          if (out_free) begin
            ovalid   <= 1'b1;
            ostatus  <= wsm_pkg::STAT_OK;
            omatched <= pend;
            oid      <= pend ? pend_id : '0;
            olast    <= 1'b1;
            pend     <= 1'b0;
            dv       <= 1'b0;
            state    <= IDLE;
          end
        end
        RESP: begin
          if (out_free) begin
            ovalid   <= 1'b1;
            ostatus  <= rstat;
            omatched <= 1'b0;
            oid      <= '0;
            olast    <= 1'b1;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sim/tb_wildcard_socket_match_table_unit.sv
`timescale 1ns / 1ps

module tb_wildcard_socket_match_table_unit;

  localparam int KIND_W   = wsm_pkg::KIND_W;
  localparam int ID_W     = wsm_pkg::ID_W;
  localparam int MAC_W    = wsm_pkg::MAC_W;
  localparam int PROTO_W  = wsm_pkg::PROTO_W;
  localparam int VLAN_W   = wsm_pkg::VLAN_W;
  localparam int STATUS_W = wsm_pkg::STATUS_W;

  localparam logic [KIND_W-1:0] KIND_CREATE = wsm_pkg::KIND_CREATE;
  localparam logic [KIND_W-1:0] KIND_DELETE = wsm_pkg::KIND_DELETE;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = wsm_pkg::KIND_LOOKUP;

  localparam logic [STATUS_W-1:0] STAT_OK        = wsm_pkg::STAT_OK;
  localparam logic [STATUS_W-1:0] STAT_EXISTS    = wsm_pkg::STAT_EXISTS;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = wsm_pkg::STAT_NOT_FOUND;
  localparam logic [STATUS_W-1:0] STAT_FULL      = wsm_pkg::STAT_FULL;

  localparam logic [MAC_W-1:0]  BCAST_MAC = wsm_pkg::BCAST_MAC;
  localparam logic [VLAN_W-1:0] VLAN_ANY  = wsm_pkg::VLAN_ANY;

  typedef wsm_pkg::entry_t entry_t;

  // The table is built at its default depth, so every entry can match a lookup and the
  // largest lookup answer is the whole table.
  localparam int DEPTH = 32;

  // Quiet time after the last pending result. A create or delete walks the table twice
  // and an unused kind produces nothing, so allow two full walks plus some margin.
  localparam int SETTLE = 2 * DEPTH + 16;

  // Length of the long receiver hold-off that lets the block back up into its input.
  localparam int HOLD_CYCLES = 400;

  // Random words per idle phase; four phases give about 220 counted words.
  localparam int PHASE_WORDS = 55;
  localparam int N_PLAN      = 20;

  // The kind value the block must ignore.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [ID_W-1:0]   ID_MAX    = {ID_W{1'b1}};
  localparam logic [MAC_W-1:0]  MAC_A     = 48'h0200_0000_0001;
  localparam logic [MAC_W-1:0]  MAC_B     = 48'h5a3c_007e_91d4;
  localparam logic [MAC_W-1:0]  MAC_NEARB = 48'hffff_ffff_fffe;
  localparam logic [VLAN_W-1:0] VLAN_NEG5 = 13'h1ffb;
  localparam logic [VLAN_W-1:0] VLAN_MIN  = 13'h1000;
  localparam logic [VLAN_W-1:0] VLAN_MAX  = 13'h0fff;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    sock_id;
    logic [MAC_W-1:0]   local_mac;
    logic [MAC_W-1:0]   remote_mac;
    logic [PROTO_W-1:0] proto_num;
    logic [VLAN_W-1:0]  vlan_num;
  } cmd_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                matched;
    logic [ID_W-1:0]     match_id;
    logic                last;
  } result_t;

  // One row of the directed plan. Where the answer is obvious (a single status word, or
  // a lookup that cannot hit anything) it is typed in; other rows go to the predictor.
  typedef struct packed {
    cmd_word_t           w;
    logic                typed;
    logic [STATUS_W-1:0] status;
  } plan_row_t;

  logic clk;
  logic rst;

  wsm_in_if  cmd ();
  wsm_out_if rsp ();

  wildcard_socket_match_table_unit #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp)
  );

  // Predictor state: the socket table sorted by id and its fill count.
  entry_t  sockets [DEPTH];
  int      n_sockets;

  // Results of the word the predictor just worked on, and all results still owed.
  result_t fresh_q [$];
  result_t owed_q  [$];

  // Idle knobs, changed between phases by the stimulus process, and the long hold-off flag.
  int      send_idle_pct;
  int      stall_pct;
  int      create_pct;
  logic    hold_off;
  event    hold_request;

  int      mismatches;
  int      words_sent;
  int      results_checked;
  int      full_hits;
  int      widest_lookup;

  // Shared value pools keep ids and field values colliding so that duplicates, deletes of
  // live entries and multi-hit lookups all happen often.
  logic [ID_W-1:0]    id_pool    [36];
  logic [MAC_W-1:0]   mac_pool   [6];
  logic [PROTO_W-1:0] proto_pool [4];
  logic [VLAN_W-1:0]  vlan_pool  [5];

  // Directed plan. The table starts empty and is empty again after the last row.
  plan_row_t plan [N_PLAN] = '{
    // Lookup on the empty table: a single no-match word.
    '{'{KIND_LOOKUP, 31'd0, MAC_A, MAC_B, 8'd6, 13'd0}, 1'b1, STAT_OK},
    // Delete of an id that was never created.
    '{'{KIND_DELETE, 31'd5, 48'd0, 48'd0, 8'd0, 13'd0}, 1'b1, STAT_NOT_FOUND},
    // Highest id, every field a wildcard.
    '{'{KIND_CREATE, ID_MAX, 48'd0, 48'd0, 8'd0, VLAN_ANY}, 1'b1, STAT_OK},
    // Lowest id, every field specific; the remote MAC near its top, protocol and VLAN at theirs.
    '{'{KIND_CREATE, 31'd0, MAC_A, MAC_NEARB, 8'd255, VLAN_MAX}, 1'b1, STAT_OK},
    // The same id again is refused.
    '{'{KIND_CREATE, 31'd0, MAC_B, MAC_B, 8'd1, 13'd1}, 1'b1, STAT_EXISTS},
    '{'{KIND_CREATE, 31'd1000, MAC_A, 48'd0, 8'd6, VLAN_ANY}, 1'b1, STAT_OK},
    // A negative VLAN other than the wildcard is an ordinary value.
    '{'{KIND_CREATE, 31'd77, 48'd0, MAC_B, 8'd0, VLAN_NEG5}, 1'b1, STAT_OK},
    '{'{KIND_LOOKUP, 31'd0, MAC_A, MAC_NEARB, 8'd255, VLAN_MAX}, 1'b0, STAT_OK},
    // Broadcast on both MACs and an untagged frame; the id field is ignored.
    '{'{KIND_LOOKUP, 31'd12345, BCAST_MAC, BCAST_MAC, 8'd6, VLAN_ANY}, 1'b0, STAT_OK},
    '{'{KIND_LOOKUP, 31'd0, 48'd0, MAC_B, 8'd0, VLAN_NEG5}, 1'b0, STAT_OK},
    '{'{KIND_LOOKUP, ID_MAX, MAC_B, MAC_A, 8'd17, VLAN_MIN}, 1'b0, STAT_OK},
    // The unused kind with every field high must leave no trace.
    '{'{KIND_UNUSED, ID_MAX, BCAST_MAC, BCAST_MAC, 8'd255, VLAN_ANY}, 1'b0, STAT_OK},
    '{'{KIND_DELETE, 31'd1000, 48'd0, 48'd0, 8'd0, 13'd0}, 1'b1, STAT_OK},
    '{'{KIND_DELETE, 31'd1000, 48'd0, 48'd0, 8'd0, 13'd0}, 1'b1, STAT_NOT_FOUND},
    '{'{KIND_LOOKUP, 31'd0, BCAST_MAC, BCAST_MAC, 8'd255, VLAN_MAX}, 1'b0, STAT_OK},
    '{'{KIND_DELETE, 31'd0, 48'd0, 48'd0, 8'd0, 13'd0}, 1'b1, STAT_OK},
    '{'{KIND_DELETE, ID_MAX, 48'd0, 48'd0, 8'd0, 13'd0}, 1'b1, STAT_OK},
    '{'{KIND_LOOKUP, 31'd0, MAC_A, MAC_B, 8'd0, VLAN_NEG5}, 1'b0, STAT_OK},
    '{'{KIND_DELETE, 31'd77, 48'd0, 48'd0, 8'd0, 13'd0}, 1'b1, STAT_OK},
    // Empty again, so even an all-broadcast frame finds nothing.
    '{'{KIND_LOOKUP, 31'd0, BCAST_MAC, BCAST_MAC, 8'd255, VLAN_MAX}, 1'b1, STAT_OK}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // An entry MAC of zero is a wildcard, and a broadcast frame MAC hits any entry.
  function automatic bit mac_hit(input logic [MAC_W-1:0] ent, input logic [MAC_W-1:0] frm);
    return ent == '0 || frm == BCAST_MAC || frm == ent;
  endfunction

  // Works out the answer words for one accepted command word and applies it to the
  // predicted table. The answer is left in fresh_q.
  function automatic void table_answer(input cmd_word_t w);
    int pos;
    fresh_q.delete();
    pos = 0;
    while (pos < n_sockets && sockets[pos].id < w.sock_id) pos++;
    case (w.kind)
      KIND_CREATE: begin
        // A duplicate id is reported ahead of a full table.
        if (pos < n_sockets && sockets[pos].id == w.sock_id) begin
          fresh_q.insert(fresh_q.size(), result_t'{STAT_EXISTS, 1'b0, '0, 1'b1});
        end else if (n_sockets >= DEPTH) begin
          fresh_q.insert(fresh_q.size(), result_t'{STAT_FULL, 1'b0, '0, 1'b1});
          full_hits++;
        end else begin
          for (int k = n_sockets; k > pos; k--) sockets[k] = sockets[k - 1];
          sockets[pos] = '{w.sock_id, w.local_mac, w.remote_mac, w.proto_num, w.vlan_num};
          n_sockets++;
          fresh_q.insert(fresh_q.size(), result_t'{STAT_OK, 1'b0, '0, 1'b1});
        end
      end
      KIND_DELETE: begin
        if (pos >= n_sockets || sockets[pos].id != w.sock_id) begin
          fresh_q.insert(fresh_q.size(), result_t'{STAT_NOT_FOUND, 1'b0, '0, 1'b1});
        end else begin
          for (int k = pos; k + 1 < n_sockets; k++) sockets[k] = sockets[k + 1];
          n_sockets--;
          fresh_q.insert(fresh_q.size(), result_t'{STAT_OK, 1'b0, '0, 1'b1});
        end
      end
      KIND_LOOKUP: begin
        // Walk in id order; protocol 0 and VLAN -1 in an entry are wildcards.
        for (int k = 0; k < n_sockets; k++) begin
          if (mac_hit(sockets[k].local_mac, w.local_mac) &&
              mac_hit(sockets[k].remote_mac, w.remote_mac) &&
              (sockets[k].proto == '0 || sockets[k].proto == w.proto_num) &&
              (sockets[k].vlan == VLAN_ANY || sockets[k].vlan == w.vlan_num)) begin
            fresh_q.insert(fresh_q.size(), result_t'{STAT_OK, 1'b1, sockets[k].id, 1'b0});
          end
        end
        if (fresh_q.size() == 0) begin
          fresh_q.insert(fresh_q.size(), result_t'{STAT_OK, 1'b0, '0, 1'b1});
        end else begin
          fresh_q[fresh_q.size() - 1].last = 1'b1;
          if (fresh_q.size() > widest_lookup) widest_lookup = fresh_q.size();
        end
      end
      default: begin
        // The unused kind changes nothing and answers nothing.
      end
    endcase
  endfunction

  function automatic logic [MAC_W-1:0] pick_mac();
    int r;
    r = $urandom_range(99);
    if (r < 8) return MAC_W'({$urandom(), $urandom()});
    if (r < 12) return BCAST_MAC;
    return mac_pool[$urandom_range(5)];
  endfunction

  function automatic logic [PROTO_W-1:0] pick_proto();
    if ($urandom_range(9) == 0) return PROTO_W'($urandom());
    return proto_pool[$urandom_range(3)];
  endfunction

  function automatic logic [VLAN_W-1:0] pick_vlan();
    if ($urandom_range(9) == 0) return VLAN_W'($urandom());
    return vlan_pool[$urandom_range(4)];
  endfunction

  // Builds one random command word. Most words are well formed and aimed at the live
  // table: creates from the shared pools with plenty of wildcards, deletes of live ids,
  // and lookups derived from a live entry so that they hit. A few are pure noise.
  function automatic cmd_word_t random_word();
    cmd_word_t w;
    entry_t    base;
    int        r;
    r = $urandom_range(99);
    w.sock_id    = id_pool[$urandom_range(35)];
    w.local_mac  = pick_mac();
    w.remote_mac = pick_mac();
    w.proto_num  = pick_proto();
    w.vlan_num   = pick_vlan();
    if (r < 3) begin
      w = {KIND_UNUSED, ID_W'($urandom()), MAC_W'({$urandom(), $urandom()}),
           MAC_W'({$urandom(), $urandom()}), PROTO_W'($urandom()), VLAN_W'($urandom())};
    end else if (r < 3 + create_pct) begin
      w.kind = KIND_CREATE;
      if ($urandom_range(2) == 0) w.local_mac = '0;
      if ($urandom_range(2) == 0) w.remote_mac = '0;
      if ($urandom_range(1) == 0) w.proto_num = '0;
      if ($urandom_range(1) == 0) w.vlan_num = VLAN_ANY;
    end else if (r < 23 + create_pct) begin
      w.kind = KIND_DELETE;
      if (n_sockets > 0 && $urandom_range(4) != 0) begin
        w.sock_id = sockets[$urandom_range(n_sockets - 1)].id;
      end
    end else begin
      w.kind = KIND_LOOKUP;
      if ($urandom_range(99) < 10) w.sock_id = ID_W'($urandom());
      if (n_sockets > 0 && $urandom_range(9) < 7) begin
        // Start from a live entry and fill its wildcards with anything.
        base = sockets[$urandom_range(n_sockets - 1)];
        if (base.local_mac != '0) w.local_mac = base.local_mac;
        if (base.remote_mac != '0) w.remote_mac = base.remote_mac;
        if (base.proto != '0) w.proto_num = base.proto;
        if (base.vlan != VLAN_ANY) w.vlan_num = base.vlan;
        if ($urandom_range(6) == 0) w.local_mac = BCAST_MAC;
        if ($urandom_range(6) == 0) w.remote_mac = BCAST_MAC;
      end
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Offers one word, holding valid until the block takes it, then logs what it owes.
  // A typed answer replaces the predicted one, though the predictor still tracks state.
  task automatic send_word(input cmd_word_t w, input logic typed,
                           input logic [STATUS_W-1:0] typed_status);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd.valid      <= 1'b1;
    cmd.kind       <= w.kind;
    cmd.sock_id    <= w.sock_id;
    cmd.local_mac  <= w.local_mac;
    cmd.remote_mac <= w.remote_mac;
    cmd.proto_num  <= w.proto_num;
    cmd.vlan_num   <= w.vlan_num;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    table_answer(w);
    if (typed) begin
      owed_q.insert(owed_q.size(), result_t'{typed_status, 1'b0, '0, 1'b1});
    end else begin
      foreach (fresh_q[k]) owed_q.insert(owed_q.size(), fresh_q[k]);
    end
    if (w.kind != KIND_UNUSED) words_sent++;
  endtask

  // The sender goes quiet until every owed result is back, then waits out any walk
  // that produces nothing.
  task automatic wait_all_back();
    @(negedge clk);
    cmd.valid <= 1'b0;
    while (owed_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Receiver side: ready changes on the falling edge only. The long hold-off wins over
  // the random stalls.
  initial begin : rsp_ready_drive
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  // The long hold-off counts its own cycles, so the sender keeps offering words while
  // the block backs up behind a stalled output.
  initial begin : long_hold
    int held;
    hold_off = 1'b0;
    forever begin
      @(hold_request);
      hold_off = 1'b1;
      held = 0;
      while (held < HOLD_CYCLES) begin
        @(posedge clk);
        held++;
      end
      hold_off = 1'b0;
    end
  end

  // Every accepted result is compared field by field with the oldest owed one.
  always @(posedge clk) begin : rsp_check
    result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      results_checked++;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed (status %0d id %0d)",
                                  rsp.status, rsp.match_id));
      end else begin
        want = owed_q.pop_front();
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
        if (rsp.matched !== want.matched)
          report_mismatch($sformatf("matched %0d, want %0d", rsp.matched, want.matched));
        if (rsp.match_id !== want.match_id)
          report_mismatch($sformatf("match_id %0d, want %0d", rsp.match_id,
                                    want.match_id));
        if (rsp.last !== want.last)
          report_mismatch($sformatf("last %0d, want %0d", rsp.last, want.last));
      end
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin : run_limit
    #5_000_000;
    $display("timeout with %0d results still owed", owed_q.size());
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int phase_sent;
    cmd_word_t w;

    n_sockets       = 0;
    mismatches      = 0;
    words_sent      = 0;
    results_checked = 0;
    full_hits       = 0;
    widest_lookup   = 0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    create_pct      = 40;

    rst            = 1'b1;
    cmd.valid      = 1'b0;
    cmd.kind       = KIND_CREATE;
    cmd.sock_id    = '0;
    cmd.local_mac  = '0;
    cmd.remote_mac = '0;
    cmd.proto_num  = '0;
    cmd.vlan_num   = '0;

    // The id pool holds both extremes so that every id bit takes both values.
    foreach (id_pool[k]) id_pool[k] = ID_W'($urandom());
    id_pool[0] = '0;
    id_pool[1] = ID_MAX;
    foreach (mac_pool[k]) mac_pool[k] = MAC_W'({$urandom(), $urandom()});
    proto_pool = '{8'd6, 8'd17, 8'd255, 8'd1};
    vlan_pool  = '{13'd0, VLAN_MAX, VLAN_NEG5, VLAN_MIN, VLAN_ANY};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, sent back to back.
    for (int k = 0; k < N_PLAN; k++) send_word(plan[k].w, plan[k].typed, plan[k].status);
    wait_all_back();

    // Random part in four idle phases: none, sender idle, receiver stalling, both.
    // The second phase leans on creates to fill the table and run into the full case.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  create_pct = 45; end
        1: begin send_idle_pct = 48; stall_pct = 0;  create_pct = 70; end
        2: begin send_idle_pct = 0;  stall_pct = 48; create_pct = 35; end
        default: begin send_idle_pct = 34; stall_pct = 34; create_pct = 45; end
      endcase
      phase_sent = 0;

      if (phase == 2) begin
        // Coming off a nearly full table, broadcast lookups return many words each,
        // and with the receiver held off the block has to stall its input.
        -> hold_request;
        repeat (6) begin
          w = '{KIND_LOOKUP, ID_W'($urandom()), BCAST_MAC, BCAST_MAC, pick_proto(),
                pick_vlan()};
          send_word(w, 1'b0, STAT_OK);
          phase_sent++;
        end
      end

      while (phase_sent < PHASE_WORDS) begin
        w = random_word();
        send_word(w, 1'b0, STAT_OK);
        if (w.kind != KIND_UNUSED) phase_sent++;
      end
      wait_all_back();
    end

    $display("Sent %0d command words and checked %0d result words.", words_sent,
             results_checked);
    $display("Table full refusals: %0d; most hits in one lookup: %0d.", full_hits,
             widest_lookup);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/wsm_pkg.sv
rtl/wsm_in_if.sv
rtl/wsm_out_if.sv
rtl/wsm_mem.sv
rtl/wsm_cmp.sv
rtl/wildcard_socket_match_table_unit.sv
sim/tb_wildcard_socket_match_table_unit.sv
